@@ src/pmx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pmx_pkg;

    localparam int LANES        = 8;
    localparam int MAX_SPEAKERS = 8;
    localparam int SUM_W        = 19;
    localparam int PROD_W       = SUM_W + 17;
    localparam int MAG_W        = PROD_W - 16;
    localparam int EXC_W        = 17;
    localparam int DIV5_SHIFT   = 18;

    localparam logic [MAG_W-1:0] KNEE      = MAG_W'(28000);
    localparam logic [15:0]      DIV5_MUL  = 16'd52429;
    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32767);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(32768);
    localparam logic [3:0]       CNT_MAX   = 4'(MAX_SPEAKERS);
    localparam logic [3:0]       CNT_LANES = 4'(LANES);

    typedef struct packed {
        logic [3:0]         speaker_count;
        logic [7:0]         present_mask;
        logic signed [15:0] sample_0;
        logic signed [15:0] sample_1;
        logic signed [15:0] sample_2;
        logic signed [15:0] sample_3;
        logic signed [15:0] sample_4;
        logic signed [15:0] sample_5;
        logic signed [15:0] sample_6;
        logic signed [15:0] sample_7;
        logic               packet_end;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic               mixed_end;
    } t_out_word;

    // lane sum plus gain, with the direct result for zero or one speaker
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [15:0]             gain;
        logic                    bypass;
        logic signed [15:0]      bypass_val;
        logic                    last;
    } t_sum_word;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic                     bypass;
        logic signed [15:0]       bypass_val;
        logic                     last;
    } t_prod_word;

    // q16 gain, round(0.85 / sqrt(n) * 65536)
    function automatic logic [15:0] gain_q16(input logic [3:0] n);
        logic [15:0] g;
        unique case (n)
            4'd1:    g = 16'd55706;
            4'd2:    g = 16'd39390;
            4'd3:    g = 16'd32162;
            4'd4:    g = 16'd27853;
            4'd5:    g = 16'd24912;
            4'd6:    g = 16'd22742;
            4'd7:    g = 16'd21055;
            4'd8:    g = 16'd19695;
            default: g = 16'd0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

@@ src/pmx_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pmx_sum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire pmx_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output pmx_pkg::t_sum_word      o_data
);
    import pmx_pkg::*;

    typedef struct packed {
        logic signed [16:0] pair0;
        logic signed [16:0] pair1;
        logic signed [16:0] pair2;
        logic signed [16:0] pair3;
        logic [3:0]         cnt;
        logic               bypass;
        logic signed [15:0] bypass_val;
        logic               last;
    } t_pair_word;

    logic signed [15:0] w_smp [8];
    logic signed [15:0] w_gated [8];
    logic [3:0]         w_cnt;
    logic [3:0]         w_lanes;
    t_pair_word         n_s1;
    t_pair_word         r_s1;
    logic               r_v1;
    t_sum_word          n_s2;
    t_sum_word          r_s2;
    logic               r_v2;
    logic               w_rdy1;
    logic               w_rdy2;

    assign w_smp[0] = i_data.sample_0;
    assign w_smp[1] = i_data.sample_1;
    assign w_smp[2] = i_data.sample_2;
    assign w_smp[3] = i_data.sample_3;
    assign w_smp[4] = i_data.sample_4;
    assign w_smp[5] = i_data.sample_5;
    assign w_smp[6] = i_data.sample_6;
    assign w_smp[7] = i_data.sample_7;

    always_comb begin
        w_cnt   = (i_data.speaker_count > CNT_MAX) ? CNT_MAX : i_data.speaker_count;
        w_lanes = (w_cnt > CNT_LANES) ? CNT_LANES : w_cnt;
        for (int k = 0; k < 8; k++) begin
            // only lanes inside the batch and present contribute
            if (i_data.present_mask[k] && (4'(k) < w_lanes)) begin
                w_gated[k] = w_smp[k];
            end else begin
                w_gated[k] = 16'sd0;
            end
        end
        n_s1.pair0 = 17'(w_gated[0]) + 17'(w_gated[1]);
        n_s1.pair1 = 17'(w_gated[2]) + 17'(w_gated[3]);
        n_s1.pair2 = 17'(w_gated[4]) + 17'(w_gated[5]);
        n_s1.pair3 = 17'(w_gated[6]) + 17'(w_gated[7]);
        n_s1.cnt    = w_cnt;
        n_s1.bypass = (w_cnt < 4'd2);
        n_s1.bypass_val = ((w_cnt == 4'd1) && i_data.present_mask[0]) ? i_data.sample_0
                                                                       : 16'sd0;
        n_s1.last = i_data.packet_end;
    end

    always_comb begin
        n_s2.sum = SUM_W'(r_s1.pair0) + SUM_W'(r_s1.pair1)
                 + SUM_W'(r_s1.pair2) + SUM_W'(r_s1.pair3);
        n_s2.gain       = gain_q16(r_s1.cnt);
        n_s2.bypass     = r_s1.bypass;
        n_s2.bypass_val = r_s1.bypass_val;
        n_s2.last       = r_s1.last;
    end

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

endmodule
`default_nettype wire

@@ src/pmx_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pmx_scale (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pmx_pkg::t_sum_word  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pmx_pkg::t_prod_word      o_data
);
    import pmx_pkg::*;

    t_prod_word n_prod;
    t_prod_word r_prod;
    logic       r_v;
    logic       w_rdy;

    always_comb begin
        // gain is unsigned, widen by a zero bit for the signed multiply
        n_prod.prod = PROD_W'(i_data.sum) * PROD_W'($signed({1'b0, i_data.gain}));
        n_prod.bypass     = i_data.bypass;
        n_prod.bypass_val = i_data.bypass_val;
        n_prod.last       = i_data.last;
    end

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_data  = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule
`default_nettype wire

@@ src/pmx_limit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pmx_limit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pmx_pkg::t_prod_word i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pmx_pkg::t_out_word       o_data
);
    import pmx_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [EXC_W-1:0]   excess;
        logic               over;
        logic               neg;
        logic               bypass;
        logic signed [15:0] bypass_val;
        logic               last;
    } t_knee_word;

    typedef struct packed {
        logic [MAG_W-1:0]         mag;
        logic [EXC_W+16-1:0]      qprod;
        logic                     over;
        logic                     neg;
        logic                     bypass;
        logic signed [15:0]       bypass_val;
        logic                     last;
    } t_div_word;

    logic [PROD_W-1:0] w_abs;
    logic [MAG_W-1:0]  w_mag;
    logic [MAG_W-1:0]  w_lim;
    logic [MAG_W-1:0]  w_q;
    t_knee_word        n_s4;
    t_knee_word        r_s4;
    logic              r_v4;
    t_div_word         n_s5;
    t_div_word         r_s5;
    logic              r_v5;
    t_out_word         n_s6;
    t_out_word         r_s6;
    logic              r_v6;
    logic              w_rdy4;
    logic              w_rdy5;
    logic              w_rdy6;

    // magnitude shift gives truncation toward zero
    always_comb begin
        w_abs = i_data.prod[PROD_W-1] ? (PROD_W'(0) - PROD_W'(i_data.prod))
                                      : PROD_W'(i_data.prod);
        w_mag = w_abs[PROD_W-1:16];
        n_s4.mag        = w_mag;
        n_s4.over       = (w_mag > KNEE);
        n_s4.excess     = EXC_W'(w_mag - KNEE);
        n_s4.neg        = i_data.prod[PROD_W-1];
        n_s4.bypass     = i_data.bypass;
        n_s4.bypass_val = i_data.bypass_val;
        n_s4.last       = i_data.last;
    end

    // excess / 5 as a reciprocal multiply, exact below 2^18
    always_comb begin
        n_s5.mag        = r_s4.mag;
        n_s5.qprod      = (EXC_W + 16)'(r_s4.excess) * (EXC_W + 16)'(DIV5_MUL);
        n_s5.over       = r_s4.over;
        n_s5.neg        = r_s4.neg;
        n_s5.bypass     = r_s4.bypass;
        n_s5.bypass_val = r_s4.bypass_val;
        n_s5.last       = r_s4.last;
    end

    always_comb begin
        w_q   = MAG_W'(r_s5.qprod >> DIV5_SHIFT);
        w_lim = r_s5.over ? (KNEE + w_q) : r_s5.mag;
        if (r_s5.bypass) begin
            n_s6.mixed_sample = r_s5.bypass_val;
        end else if (r_s5.neg) begin
            n_s6.mixed_sample = (w_lim > NEG_LIMIT) ? -16'sd32768
                                                    : 16'(NEG_LIMIT - w_lim) ^ 16'h8000;
        end else begin
            n_s6.mixed_sample = (w_lim > POS_LIMIT) ? 16'sd32767 : 16'(w_lim);
        end
        n_s6.mixed_end = r_s5.last;
    end

    assign w_rdy6  = !r_v6 || i_ready;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign o_ready = w_rdy4;
    assign o_valid = r_v6;
    assign o_data  = r_s6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy4) begin
                r_v4 <= i_valid;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && i_valid) begin
            r_s4 <= n_s4;
        end
        if (w_rdy5 && r_v4) begin
            r_s5 <= n_s5;
        end
        if (w_rdy6 && r_v5) begin
            r_s6 <= n_s6;
        end
    end

endmodule
`default_nettype wire

@@ src/pcm16_multi_speaker_mixer_core.sv @@
// an accepted word is registered in r_s1, r_s2, r_prod, r_s4, r_s5 and r_s6 in order
// throughput: one word per cycle; every stage is a valid/ready register so a stall
//   holds words in place and bubbles are squeezed out
// the two multipliers (gain, divide-by-five reciprocal) each sit alone in a stage
// reset: synchronous active low, clears the stage valid bits only; no other state
`timescale 1ns / 1ps
`default_nettype none
module pcm16_multi_speaker_mixer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pmx_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pmx_pkg::t_out_word      o_out_data
);
    import pmx_pkg::*;

    logic       w_sum_valid;
    logic       w_sum_ready;
    t_sum_word  w_sum_data;
    logic       w_prod_valid;
    logic       w_prod_ready;
    t_prod_word w_prod_data;

    pmx_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_sum_valid),
        .i_ready (w_sum_ready),
        .o_data  (w_sum_data)
    );

    pmx_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .o_ready (w_sum_ready),
        .i_data  (w_sum_data),
        .o_valid (w_prod_valid),
        .i_ready (w_prod_ready),
        .o_data  (w_prod_data)
    );

    pmx_limit u_limit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_valid),
        .o_ready (w_prod_ready),
        .i_data  (w_prod_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire
